>>> src/fwte_pkg.sv
// ----------------------------------------------------------------------------
// fwte_pkg
// Shared types and constants of the frame wait time encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fwte_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ScW   = 21;
  localparam int unsigned ExpW  = 4;
  localparam int unsigned MulW  = 8;
  localparam int unsigned DlyW  = 7;
  localparam int unsigned NumW  = 16;
  localparam int unsigned CntW  = $clog2(NumW);

  localparam logic [2:0] ProtoA      = 3'd2;
  localparam logic [2:0] ProtoB      = 3'd3;
  localparam logic [2:0] ProtoFelica = 3'd4;

  localparam logic [TimeW-1:0] FelicaCeil = TimeW'((128 + 1) * 128 * 32);
  localparam logic [TimeW-1:0] OtherCeil  = TimeW'((128 + 1) * 255 * 32);

  localparam int unsigned StepUnit = 255 * 32;

  typedef struct packed {
    logic [ScW-1:0]  t;
    logic [ExpW-1:0] exp;
  } scale_res_t;

  typedef struct packed {
    logic [ExpW-1:0] pre;
    logic [MulW-1:0] mul;
    logic [DlyW-1:0] dly;
  } timing_t;

endpackage

`default_nettype wire

>>> src/frame_wait_time_encoder.sv
// ----------------------------------------------------------------------------
// frame_wait_time_encoder
// Encodes a frame waiting time into prescaler exponent, multiplier and delay.
// ----------------------------------------------------------------------------
// The scaler halves the clamped wait time one bit per cycle, h times (0 to
// 13), until it is no longer above the mode ceiling. Outside FeliCa mode the
// 16-step serial divider then works out the delay. One transaction at a time:
// the next is accepted only once the last result is loaded for output.
// Reset: max_wait_time returns to all ones, cached timings to their defaults,
// no result pending.
`default_nettype none

module frame_wait_time_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // wait_time
  input  wire logic [2:0]  s_axis_tuser,  // protocol
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // prescale_exp, multiplier, delay, reselect_needed
);
  import fwte_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScale = 4'b0010,
    StDiv   = 4'b0100,
    StHold  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [TimeW-1:0] max_wait_q;
  logic [2:0]       proto_q;
  timing_t          res_q;
  timing_t          res_d;
  timing_t          cache_a_q, cache_b_q, cache_f_q;
  logic             out_valid_q;
  logic [23:0]      out_data_q;

  logic             in_acc;
  logic             sc_done;
  scale_res_t       sc_res;
  logic             div_start;
  logic             div_done;
  logic [NumW-1:0]  div_quo;
  logic             div_rem_nz;
  logic [MulW-1:0]  mul_c;
  logic [ScW-1:0]   t_rnd;
  logic [NumW-1:0]  dly_raw;
  logic             load_out;
  logic             resel;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  fwte_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .felica_i    (s_axis_tuser == ProtoFelica),
    .wait_time_i (s_axis_tdata),
    .max_wait_i  (max_wait_q),
    .done_o      (sc_done),
    .res_o       (sc_res)
  );

  always_comb begin
    if (proto_q == ProtoFelica) begin
      mul_c = sc_res.t[19:12];
    end else begin
      priority if (sc_res.t > ScW'(65 * StepUnit)) mul_c = MulW'(128);
      else if (sc_res.t > ScW'(33 * StepUnit))     mul_c = MulW'(64);
      else if (sc_res.t > ScW'(17 * StepUnit))     mul_c = MulW'(32);
      else if (sc_res.t > ScW'(9 * StepUnit))      mul_c = MulW'(16);
      else if (sc_res.t > ScW'(5 * StepUnit))      mul_c = MulW'(8);
      else if (sc_res.t > ScW'(3 * StepUnit))      mul_c = MulW'(4);
      else if (sc_res.t > ScW'(2 * StepUnit))      mul_c = MulW'(2);
      else if (sc_res.t > ScW'(StepUnit))          mul_c = MulW'(1);
      else                                         mul_c = '0;
    end
    t_rnd = sc_res.t + ScW'(31);
  end

  assign div_start = (state_q == StScale) && sc_done && (proto_q != ProtoFelica);

  fwte_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (t_rnd[ScW-1:5]),
    .den_i    (mul_c + MulW'(1)),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  assign dly_raw  = div_quo + NumW'(div_rem_nz);
  assign load_out = (state_q == StHold) && (!out_valid_q || m_axis_tready);

  always_comb begin
    res_d   = res_q;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StScale;
      end
      StScale: begin
        if (sc_done) begin
          res_d.pre = sc_res.exp;
          res_d.mul = mul_c;
          res_d.dly = '0;
          state_d   = (proto_q == ProtoFelica) ? StHold : StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          res_d.dly = (dly_raw > NumW'(128)) ? DlyW'(dly_raw - NumW'(128)) : '0;
          state_d   = StHold;
        end
      end
      StHold: begin
        if (load_out) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    unique case (proto_q)
      ProtoA:      resel = (cache_a_q != res_q);
      ProtoB:      resel = (cache_b_q != res_q);
      ProtoFelica: resel = (cache_f_q != res_q);
      default:     resel = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_wait_q  <= '1;
      out_valid_q <= 1'b0;
      cache_a_q   <= '{pre: ExpW'(0), mul: MulW'(0), dly: DlyW'(0)};
      cache_b_q   <= '{pre: ExpW'(0), mul: MulW'(0), dly: DlyW'('h70)};
      cache_f_q   <= '{pre: ExpW'(6), mul: MulW'(0), dly: DlyW'(0)};
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_wait_q <= cfg_data_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (proto_q == ProtoA)      cache_a_q <= res_q;
        if (proto_q == ProtoB)      cache_b_q <= res_q;
        if (proto_q == ProtoFelica) cache_f_q <= res_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) proto_q <= s_axis_tuser;
    res_q <= res_d;
    if (load_out) begin
      out_data_q <= {4'b0, resel, res_q.dly, res_q.mul, res_q.pre};
    end
  end

endmodule

`default_nettype wire

>>> src/fwte_scale.sv
// ----------------------------------------------------------------------------
// fwte_scale
// Clamps the wait time and halves it one bit per cycle until not above the mode ceiling.
// ----------------------------------------------------------------------------
`default_nettype none

module fwte_scale (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        felica_i,
  input  wire logic [fwte_pkg::TimeW-1:0]  wait_time_i,
  input  wire logic [fwte_pkg::TimeW-1:0]  max_wait_i,
  output logic                             done_o,
  output fwte_pkg::scale_res_t             res_o
);
  import fwte_pkg::*;

  logic             busy_q;
  logic             felica_q;
  logic [TimeW-1:0] t_q;
  logic [ExpW-1:0]  exp_q;
  logic             over;

  always_comb begin
    over   = felica_q ? (t_q > FelicaCeil) : (t_q > OtherCeil);
    done_o = busy_q && !over;
    res_o  = '{t: t_q[ScW-1:0], exp: exp_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && !over) begin
      busy_q <= 1'b0;
    end
  end

  // shift one bit per cycle until no longer above the ceiling
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q      <= (wait_time_i > max_wait_i) ? max_wait_i : wait_time_i;
      exp_q    <= '0;
      felica_q <= felica_i;
    end else if (busy_q && over) begin
      t_q   <= {1'b0, t_q[TimeW-1:1]};
      exp_q <= exp_q + ExpW'(1);
    end
  end

endmodule

`default_nettype wire

>>> src/fwte_div.sv
// ----------------------------------------------------------------------------
// fwte_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fwte_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [fwte_pkg::NumW-1:0]  num_i,
  input  wire logic [fwte_pkg::MulW-1:0]  den_i,
  output logic                            done_o,
  output logic [fwte_pkg::NumW-1:0]       quo_o,
  output logic                            rem_nz_o
);
  import fwte_pkg::*;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [MulW-1:0] rem_q;
  logic [MulW-1:0] den_q;
  logic [MulW:0]   trial;
  logic            fits;

  always_comb begin
    trial    = {rem_q, quo_q[NumW-1]};
    fits     = trial >= {1'b0, den_q};
    done_o   = done_q;
    quo_o    = quo_q;
    rem_nz_o = (rem_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntW'(NumW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= fits ? MulW'(trial - {1'b0, den_q}) : trial[MulW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_frame_wait_time_encoder.sv
// ----------------------------------------------------------------------------
// tb_frame_wait_time_encoder
// Self-checking bench for the frame wait time encoder. A tracker class keeps
// its own copy of the clamp limit and of the cached A, B and FeliCa timings.
// It works out the expected exponent, multiplier, delay and reselect flag of
// every accepted request and compares each returned transaction against them.
// Directed corner cases come first. Random phases follow under several clamp
// limits, with random gaps and stalls on both streams in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_wait_time_encoder;
  import fwte_pkg::*;

  localparam logic [2:0]  ProtoOff      = 3'd0;
  localparam logic [2:0]  ProtoIso15693 = 3'd1;
  localparam logic [2:0]  ProtoCardEmuA = 3'd5;
  localparam int unsigned FelicaUnit    = 128 * 32;
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned PhaseItems    = 150;
  localparam int unsigned SinkHoldCycles = 400;

  typedef struct packed {
    logic [3:0] exp;
    logic [7:0] mul;
    logic [6:0] dly;
    logic       resel;
  } encoded_timing_t;

  class timing_tracker;
    logic [31:0]     wait_limit;
    timing_t         cache_a;
    timing_t         cache_b;
    timing_t         cache_felica;
    encoded_timing_t timing_due_q[$];

    function new();
      wait_limit   = 32'hFFFF_FFFF;
      cache_a      = '{pre: 4'd0, mul: 8'd0, dly: 7'd0};
      cache_b      = '{pre: 4'd0, mul: 8'd0, dly: 7'h70};
      cache_felica = '{pre: 4'd6, mul: 8'd0, dly: 7'd0};
    endfunction

    function void set_limit(logic [31:0] limit);
      wait_limit = limit;
    endfunction

    function int unsigned outstanding();
      return timing_due_q.size();
    endfunction

    function void note_request(logic [2:0] proto, logic [31:0] req);
      int unsigned     t;
      int unsigned     m;
      int unsigned     q;
      encoded_timing_t e;
      timing_t         fresh;
      e = '0;
      t = (req > wait_limit) ? wait_limit : req;
      if (proto == ProtoFelica) begin
        while (t > FelicaCeil) begin
          e.exp++;
          t = t >> 1;
        end
        e.mul = 8'(t / FelicaUnit);
        e.dly = '0;
      end else begin
        while (t > OtherCeil) begin
          e.exp++;
          t = t >> 1;
        end
        m = 128;
        while (m > 0 && !(t > (m / 2 + 1) * StepUnit))
          m = m / 2;
        if (m == 0)
          m = (t > StepUnit) ? 1 : 0;
        e.mul = 8'(m);
        q = ((t + 31) / 32 + m) / (m + 1);
        e.dly = 7'((q > 128) ? q - 128 : 0);
      end
      fresh = '{pre: e.exp, mul: e.mul, dly: e.dly};
      if (proto == ProtoA) begin
        e.resel = (cache_a != fresh);
        cache_a = fresh;
      end else if (proto == ProtoB) begin
        e.resel = (cache_b != fresh);
        cache_b = fresh;
      end else if (proto == ProtoFelica) begin
        e.resel = (cache_felica != fresh);
        cache_felica = fresh;
      end
      timing_due_q.push_back(e);
    endfunction

    function bit check_timing(logic [23:0] data, output string msg);
      encoded_timing_t got;
      encoded_timing_t want;
      got = '{exp: data[3:0], mul: data[11:4], dly: data[18:12], resel: data[19]};
      if (timing_due_q.size() == 0) begin
        msg = $sformatf("unexpected transaction exp=%0d mul=%0d dly=%0d resel=%0d",
                        got.exp, got.mul, got.dly, got.resel);
        return 1'b0;
      end
      want = timing_due_q.pop_front();
      if (got.exp == want.exp && got.mul == want.mul && got.dly == want.dly &&
          got.resel == want.resel)
        return 1'b1;
      msg = $sformatf("exp %0d/%0d mul %0d/%0d dly %0d/%0d resel %0d/%0d (got/want)",
                      got.exp, want.exp, got.mul, want.mul, got.dly, want.dly,
                      got.resel, want.resel);
      return 1'b0;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // wait_time
  logic [2:0]  s_axis_tuser;  // protocol
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // prescale_exp, multiplier, delay, reselect_needed

  timing_tracker tracker;
  int unsigned   mismatch_count = 0;
  int unsigned   sink_hold = 0;
  int unsigned   hold_req = 0;
  int unsigned   hold_ack = 0;
  bit            src_steady = 1'b0;
  bit            sink_steady = 1'b0;

  frame_wait_time_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_500_000;
    $display("frame_wait_time_encoder verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic send_request(input logic [2:0] proto, input logic [31:0] req);
    @(negedge clk_i);
    while (!src_steady && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = req;
    s_axis_tuser  = proto;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_request(proto, req);
  endtask

  task automatic drop_request();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] limit);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_limit(limit);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_wait_time();
    int unsigned base;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: begin
        case ($urandom_range(0, 2))
          0: base = FelicaCeil;
          1: base = OtherCeil;
          default: base = ((1 << $urandom_range(0, 7)) / 2 + 1) * StepUnit;
        endcase
        base = base << $urandom_range(0, 11);
        return base + $urandom_range(0, 64) - 32;
      end
      default: return $urandom_range(0, OtherCeil);
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      sink_hold = SinkHoldCycles;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = sink_steady || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (!tracker.check_timing(m_axis_tdata, msg))
        report_mismatch(msg);
    end
  end

  initial begin
    logic [31:0] limits[7];
    logic [2:0]  proto;
    logic [31:0] req;
    tracker       = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ProtoOff;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(ProtoA, 32'd0);
    send_request(ProtoA, 32'd0);
    send_request(ProtoB, 32'd0);
    send_request(ProtoB, 32'd30720);
    send_request(ProtoFelica, 32'd0);
    send_request(ProtoFelica, FelicaCeil);
    send_request(ProtoFelica, FelicaCeil + 1);
    send_request(ProtoFelica, 32'hFFFF_FFFF);
    send_request(ProtoA, OtherCeil);
    send_request(ProtoA, OtherCeil + 1);
    send_request(ProtoA, 32'hFFFF_FFFF);
    send_request(ProtoA, 32'hFFFF_FFFF);
    send_request(ProtoB, 65 * StepUnit);
    send_request(ProtoB, 65 * StepUnit + 1);
    send_request(ProtoIso15693, StepUnit);
    send_request(ProtoCardEmuA, StepUnit + 1);
    for (int p = 0; p < 8; p++)
      send_request(3'(p), $urandom);
    drop_request();
    drain();
    write_limit(32'd0);
    send_request(ProtoA, 32'hFFFF_FFFF);
    send_request(ProtoFelica, 32'hFFFF_FFFF);
    drop_request();
    drain();

    limits[0] = 32'hFFFF_FFFF;
    limits[1] = $urandom;
    limits[2] = OtherCeil;
    limits[3] = FelicaCeil << $urandom_range(1, 8);
    limits[4] = 32'd0;
    limits[5] = $urandom_range(0, 20000);
    limits[6] = 32'hFFFF_FFFF;
    proto = ProtoA;
    req   = '0;
    for (int ph = 0; ph < 7; ph++) begin
      write_limit(limits[ph]);
      src_steady  = (ph == 2);
      sink_steady = (ph == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 1 && n == 40)
          hold_req++;
        if (ph == 3 && n == 75) begin
          drop_request();
          while (tracker.outstanding() != 0) @(posedge clk_i);
        end
        if (n == 0 || $urandom_range(0, 3) != 0) begin
          proto = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(ProtoA, ProtoFelica))
                                               : 3'($urandom_range(0, 7));
          req   = pick_wait_time();
        end
        send_request(proto, req);
      end
      drop_request();
      drain();
    end

    if (mismatch_count == 0)
      $display("frame_wait_time_encoder verification clean");
    else
      $display("frame_wait_time_encoder verification failed");
    $finish;
  end

endmodule

>>> files.f
src/fwte_pkg.sv
src/fwte_scale.sv
src/fwte_div.sv
src/frame_wait_time_encoder.sv
sim/tb_frame_wait_time_encoder.sv
